FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CHK_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CHK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

FILE: rtl/cpu8_exec_pkg.sv
`timescale 1ns / 1ps

package cpu8_exec_pkg;

   localparam int REQ_W = 32;
   localparam int RSP_W = 120;

   localparam logic [15:0] SP_RESET = 16'hFFFE;
   localparam logic [15:0] PC_RESET = 16'h0100;

   // memory write counts
   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_ONE  = 2'd1;
   localparam logic [1:0] WR_TWO  = 2'd2;

   // instruction lengths
   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   // opcodes
   localparam logic [7:0] OP_LD_BC_D16 = 8'h01;
   localparam logic [7:0] OP_ST_BC_A   = 8'h02;
   localparam logic [7:0] OP_INC_BC    = 8'h03;
   localparam logic [7:0] OP_INC_B     = 8'h04;
   localparam logic [7:0] OP_DEC_B     = 8'h05;
   localparam logic [7:0] OP_LD_B_D8   = 8'h06;
   localparam logic [7:0] OP_RLCA      = 8'h07;
   localparam logic [7:0] OP_ST_A16_SP = 8'h08;
   localparam logic [7:0] OP_ADD_HL_BC = 8'h09;
   localparam logic [7:0] OP_LD_A_BC   = 8'h0A;
   localparam logic [7:0] OP_DEC_BC    = 8'h0B;
   localparam logic [7:0] OP_INC_C     = 8'h0C;
   localparam logic [7:0] OP_DEC_C     = 8'h0D;
   localparam logic [7:0] OP_LD_C_D8   = 8'h0E;
   localparam logic [7:0] OP_RRCA      = 8'h0F;
   localparam logic [7:0] OP_LD_DE_D16 = 8'h11;
   localparam logic [7:0] OP_ST_DE_A   = 8'h12;
   localparam logic [7:0] OP_INC_DE    = 8'h13;
   localparam logic [7:0] OP_INC_D     = 8'h14;
   localparam logic [7:0] OP_DEC_D     = 8'h15;
   localparam logic [7:0] OP_LD_D_D8   = 8'h16;
   localparam logic [7:0] OP_RLA       = 8'h17;
   localparam logic [7:0] OP_JR        = 8'h18;
   localparam logic [7:0] OP_ADD_HL_DE = 8'h19;
   localparam logic [7:0] OP_LD_A_DE   = 8'h1A;
   localparam logic [7:0] OP_DEC_DE    = 8'h1B;
   localparam logic [7:0] OP_INC_E     = 8'h1C;
   localparam logic [7:0] OP_DEC_E     = 8'h1D;
   localparam logic [7:0] OP_LD_E_D8   = 8'h1E;
   localparam logic [7:0] OP_RRA       = 8'h1F;
   localparam logic [7:0] OP_JR_NZ     = 8'h20;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [7:0] value;
      flags_type  flags;
   } alu8_type;

   // last field in the low bits
   typedef struct packed {
      logic [7:0] load_data;
      logic [7:0] imm_high;
      logic [7:0] imm_low;
      logic [7:0] cmd;
   } req_data_type;

   typedef struct packed {
      logic [4:0]  pad;
      logic        branch_taken;
      logic [15:0] next_pc;
      logic [15:0] pair_hl;
      logic [15:0] pair_de;
      logic [15:0] pair_bc;
      logic [7:0]  flags_out;
      logic [7:0]  acc_out;
      logic [7:0]  write_second;
      logic [7:0]  write_first;
      logic [15:0] write_addr;
      logic [1:0]  write_count;
   } rsp_data_type;

endpackage

FILE: rtl/cpu8_opcode_subset_execute_top.sv
`timescale 1ns / 1ps

// Executes one instruction of a small 8-bit CPU subset (opcodes 0x01-0x20: immediate
// loads, A loads/stores through BC or DE, 8- and 16-bit INC/DEC, ADD HL, the accumulator
// rotates, LD (a16),SP, JR and JR NZ; anything else is a one-byte NOP) per request
// transaction. The block holds A, F, BC, DE, HL and PC and returns their new values, the
// next PC and any memory write in one response transaction. Decode and execute sit in
// one combinational pass from the request port into the response register, and a new
// instruction is taken every cycle while the response is being taken or the register is
// empty. SP is written through csr_wdata/csr_wen.
module cpu8_opcode_subset_execute_top import cpu8_exec_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // [7:0] cmd, [15:8] imm_low, [23:16] imm_high, [31:24] load_data
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [1:0] write_count, [17:2] write_addr, [25:18] write_first, [33:26] write_second,
   // [41:34] acc_out, [49:42] flags_out, [65:50] pair_bc, [81:66] pair_de,
   // [97:82] pair_hl, [113:98] next_pc, [114] branch_taken, [119:115] zero
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_wen,
   input  logic [15:0]      csr_wdata
);

   req_data_type req;
   logic         accept;
   logic [15:0]  imm16;

   logic [7:0]   acc_ff, acc_in;
   flags_type    flags_ff, flags_in;
   logic [15:0]  bc_ff, bc_in;
   logic [15:0]  de_ff, de_in;
   logic [15:0]  hl_ff, hl_in;
   logic [15:0]  pc_ff, pc_in;
   logic [15:0]  sp_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   logic [1:0]   len;
   logic         taken;
   logic [15:0]  pc_seq;
   logic [15:0]  pc_jump;
   alu8_type     alu;
   logic [15:0]  add_src;
   logic [16:0]  add_sum;
   logic [12:0]  add_half;
   logic [1:0]   wr_count;
   logic [15:0]  wr_addr;
   logic [7:0]   wr_first;
   logic [7:0]   wr_second;

   function automatic alu8_type inc8(input logic [7:0] v, input flags_type f);
      alu8_type r;
      r.value   = v + 8'd1;
      r.flags.z = (r.value == 8'd0);
      r.flags.n = 1'b0;
      r.flags.h = (v[3:0] == 4'hF);
      r.flags.c = f.c;
      return r;
   endfunction

   function automatic alu8_type dec8(input logic [7:0] v, input flags_type f);
      alu8_type r;
      r.value   = v - 8'd1;
      r.flags.z = (r.value == 8'd0);
      r.flags.n = 1'b1;
      r.flags.h = (v[3:0] == 4'h0);
      r.flags.c = f.c;
      return r;
   endfunction

   assign req        = req_data_type'(req_tdata);
   assign imm16      = {req.imm_high, req.imm_low};
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // shared 8-bit INC/DEC unit, operand picked by the register field of the opcode
   always_comb begin
      unique case (req.cmd) inside
         OP_INC_B: alu = inc8(bc_ff[15:8], flags_ff);
         OP_DEC_B: alu = dec8(bc_ff[15:8], flags_ff);
         OP_INC_C: alu = inc8(bc_ff[7:0], flags_ff);
         OP_DEC_C: alu = dec8(bc_ff[7:0], flags_ff);
         OP_INC_D: alu = inc8(de_ff[15:8], flags_ff);
         OP_DEC_D: alu = dec8(de_ff[15:8], flags_ff);
         OP_INC_E: alu = inc8(de_ff[7:0], flags_ff);
         OP_DEC_E: alu = dec8(de_ff[7:0], flags_ff);
         default:  alu = '{value: 8'd0, flags: flags_ff};
      endcase
   end

   assign add_src  = (req.cmd == OP_ADD_HL_DE) ? de_ff : bc_ff;
   assign add_sum  = {1'b0, hl_ff} + {1'b0, add_src};
   assign add_half = {1'b0, hl_ff[11:0]} + {1'b0, add_src[11:0]};

   always_comb begin
      acc_in    = acc_ff;
      flags_in  = flags_ff;
      bc_in     = bc_ff;
      de_in     = de_ff;
      hl_in     = hl_ff;
      len       = LEN_ONE;
      taken     = 1'b0;
      wr_count  = WR_NONE;
      wr_addr   = 16'd0;
      wr_first  = 8'd0;
      wr_second = 8'd0;
      unique case (req.cmd) inside
         OP_LD_BC_D16: begin
            bc_in = imm16;
            len   = LEN_THREE;
         end
         OP_LD_DE_D16: begin
            de_in = imm16;
            len   = LEN_THREE;
         end
         OP_ST_BC_A: begin
            wr_count = WR_ONE;
            wr_addr  = bc_ff;
            wr_first = acc_ff;
         end
         OP_ST_DE_A: begin
            wr_count = WR_ONE;
            wr_addr  = de_ff;
            wr_first = acc_ff;
         end
         OP_INC_BC: bc_in = bc_ff + 16'd1;
         OP_INC_DE: de_in = de_ff + 16'd1;
         OP_DEC_BC: bc_in = bc_ff - 16'd1;
         OP_DEC_DE: de_in = de_ff - 16'd1;
         OP_INC_B, OP_DEC_B: begin
            bc_in    = {alu.value, bc_ff[7:0]};
            flags_in = alu.flags;
         end
         OP_INC_C, OP_DEC_C: begin
            bc_in    = {bc_ff[15:8], alu.value};
            flags_in = alu.flags;
         end
         OP_INC_D, OP_DEC_D: begin
            de_in    = {alu.value, de_ff[7:0]};
            flags_in = alu.flags;
         end
         OP_INC_E, OP_DEC_E: begin
            de_in    = {de_ff[15:8], alu.value};
            flags_in = alu.flags;
         end
         OP_LD_B_D8: begin
            bc_in = {req.imm_low, bc_ff[7:0]};
            len   = LEN_TWO;
         end
         OP_LD_C_D8: begin
            bc_in = {bc_ff[15:8], req.imm_low};
            len   = LEN_TWO;
         end
         OP_LD_D_D8: begin
            de_in = {req.imm_low, de_ff[7:0]};
            len   = LEN_TWO;
         end
         OP_LD_E_D8: begin
            de_in = {de_ff[15:8], req.imm_low};
            len   = LEN_TWO;
         end
         OP_RLCA: begin
            acc_in   = {acc_ff[6:0], acc_ff[7]};
            flags_in = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_ff[7]};
         end
         OP_RRCA: begin
            acc_in   = {acc_ff[0], acc_ff[7:1]};
            flags_in = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_ff[0]};
         end
         OP_RLA: begin
            acc_in   = {acc_ff[6:0], flags_ff.c};
            flags_in = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_ff[7]};
         end
         OP_RRA: begin
            acc_in   = {flags_ff.c, acc_ff[7:1]};
            flags_in = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_ff[0]};
         end
         OP_ST_A16_SP: begin
            wr_count  = WR_TWO;
            wr_addr   = imm16;
            wr_first  = sp_ff[7:0];
            wr_second = sp_ff[15:8];
            len       = LEN_THREE;
         end
         OP_ADD_HL_BC, OP_ADD_HL_DE: begin
            hl_in    = add_sum[15:0];
            flags_in = '{z: flags_ff.z, n: 1'b0, h: add_half[12], c: add_sum[16]};
         end
         OP_LD_A_BC, OP_LD_A_DE: acc_in = req.load_data;
         OP_JR: begin
            len   = LEN_TWO;
            taken = 1'b1;
         end
         // offset byte is consumed whether or not the branch goes
         OP_JR_NZ: begin
            len   = LEN_TWO;
            taken = !flags_ff.z;
         end
         default: ;
      endcase
   end

   assign pc_seq  = pc_ff + {14'd0, len};
   assign pc_jump = pc_seq + {{8{req.imm_low[7]}}, req.imm_low};
   assign pc_in   = taken ? pc_jump : pc_seq;

   always_comb begin
      rsp_data_in              = '0;
      rsp_data_in.write_count  = wr_count;
      rsp_data_in.write_addr   = wr_addr;
      rsp_data_in.write_first  = wr_first;
      rsp_data_in.write_second = wr_second;
      rsp_data_in.acc_out      = acc_in;
      rsp_data_in.flags_out    = {flags_in, 4'd0};
      rsp_data_in.pair_bc      = bc_in;
      rsp_data_in.pair_de      = de_in;
      rsp_data_in.pair_hl      = hl_in;
      rsp_data_in.next_pc      = pc_in;
      rsp_data_in.branch_taken = taken;
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 8'd0;
         flags_ff     <= '0;
         bc_ff        <= 16'd0;
         de_ff        <= 16'd0;
         hl_ff        <= 16'd0;
         pc_ff        <= PC_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            acc_ff   <= acc_in;
            flags_ff <= flags_in;
            bc_ff    <= bc_in;
            de_ff    <= de_in;
            hl_ff    <= hl_in;
            pc_ff    <= pc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= SP_RESET;
      end else if (csr_wen) begin
         sp_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule

FILE: rtl/cpu8_exec_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpu8_exec_checker import cpu8_exec_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // a held response keeps its payload
   `CHK_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // every accepted request shows up as a response on the next cycle
   `CHK_NEXT(a_req_to_rsp, req_tvalid && req_tready, rsp_tvalid)
   // flag byte carries nothing in its low nibble
   `CHK_SAME(a_flags_low, rsp_tvalid, rsp_tdata[45:42] == 4'd0)
   // a taken branch never writes memory
   `CHK_SAME(a_jump_no_wr, rsp_tvalid && rsp_tdata[114], rsp_tdata[1:0] == WR_NONE)
   // write count is never the unused code
   `CHK_SAME(a_wr_count, rsp_tvalid, rsp_tdata[1:0] != 2'd3)

endmodule

bind cpu8_opcode_subset_execute_top cpu8_exec_checker u_cpu8_exec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import cpu8_exec_pkg::*;

   localparam logic [7:0] OP_NOP      = 8'h00;
   localparam logic [7:0] OP_STOP     = 8'h10;
   localparam logic [7:0] OP_UNUSED   = 8'hFF;
   localparam int         CYCLE_LIMIT = 600000;
   localparam int         HOLD_CYCLES = 300;
   localparam int         SETTLE      = 4;
   localparam int         CHUNK_ITEMS = 330;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_wen    = 1'b0;
   logic [15:0]      csr_wdata  = '0;

   // architectural state tracked by the predictor
   logic [7:0]  a_q;
   flags_type   flg_q;
   logic [15:0] bc_q;
   logic [15:0] de_q;
   logic [15:0] hl_q;
   logic [15:0] pc_q;
   logic [15:0] sp_q;

   req_data_type insn_q[$];
   rsp_data_type result_q[$];

   int   tx_idle_pct = 20;
   int   rx_idle_pct = 20;
   int   tx_gap      = 0;
   int   rx_stall    = 0;
   logic rx_hold     = 1'b0;

   int err_cnt    = 0;
   int insn_cnt   = 0;
   int result_cnt = 0;
   int jump_cnt   = 0;
   int store_cnt  = 0;
   int cycle_cnt  = 0;

   cpu8_opcode_subset_execute_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] inc8(input logic [7:0] v);
      logic [7:0] r;
      r = v + 8'd1;
      flg_q.z = (r == 8'h00);
      flg_q.n = 1'b0;
      flg_q.h = (v[3:0] == 4'hF);
      return r;
   endfunction

   function automatic logic [7:0] dec8(input logic [7:0] v);
      logic [7:0] r;
      r = v - 8'd1;
      flg_q.z = (r == 8'h00);
      flg_q.n = 1'b1;
      flg_q.h = (v[3:0] == 4'h0);
      return r;
   endfunction

   // Z is left alone; H is carry out of bit 11
   function automatic void add_hl(input logic [15:0] v);
      logic [16:0] sum;
      logic [12:0] low;
      sum = {1'b0, hl_q} + {1'b0, v};
      low = {1'b0, hl_q[11:0]} + {1'b0, v[11:0]};
      flg_q.n = 1'b0;
      flg_q.h = low[12];
      flg_q.c = sum[16];
      hl_q = sum[15:0];
   endfunction

   function automatic rsp_data_type exec_insn(input req_data_type rq);
      rsp_data_type r;
      logic [15:0]  imm16;
      logic [1:0]   len;
      logic         taken;
      logic         out_bit;
      imm16 = {rq.imm_high, rq.imm_low};
      r = '0;
      len = LEN_ONE;
      taken = 1'b0;
      case (rq.cmd)
         OP_LD_BC_D16: begin
            bc_q = imm16;
            len = LEN_THREE;
         end
         OP_LD_DE_D16: begin
            de_q = imm16;
            len = LEN_THREE;
         end
         OP_ST_BC_A: begin
            r.write_count = WR_ONE;
            r.write_addr = bc_q;
            r.write_first = a_q;
         end
         OP_ST_DE_A: begin
            r.write_count = WR_ONE;
            r.write_addr = de_q;
            r.write_first = a_q;
         end
         OP_INC_BC: bc_q = bc_q + 16'd1;
         OP_INC_DE: de_q = de_q + 16'd1;
         OP_DEC_BC: bc_q = bc_q - 16'd1;
         OP_DEC_DE: de_q = de_q - 16'd1;
         OP_INC_B:  bc_q[15:8] = inc8(bc_q[15:8]);
         OP_DEC_B:  bc_q[15:8] = dec8(bc_q[15:8]);
         OP_INC_C:  bc_q[7:0] = inc8(bc_q[7:0]);
         OP_DEC_C:  bc_q[7:0] = dec8(bc_q[7:0]);
         OP_INC_D:  de_q[15:8] = inc8(de_q[15:8]);
         OP_DEC_D:  de_q[15:8] = dec8(de_q[15:8]);
         OP_INC_E:  de_q[7:0] = inc8(de_q[7:0]);
         OP_DEC_E:  de_q[7:0] = dec8(de_q[7:0]);
         OP_LD_B_D8: begin
            bc_q[15:8] = rq.imm_low;
            len = LEN_TWO;
         end
         OP_LD_C_D8: begin
            bc_q[7:0] = rq.imm_low;
            len = LEN_TWO;
         end
         OP_LD_D_D8: begin
            de_q[15:8] = rq.imm_low;
            len = LEN_TWO;
         end
         OP_LD_E_D8: begin
            de_q[7:0] = rq.imm_low;
            len = LEN_TWO;
         end
         OP_RLCA: begin
            out_bit = a_q[7];
            a_q = {a_q[6:0], out_bit};
            flg_q = {3'b000, out_bit};
         end
         OP_RRCA: begin
            out_bit = a_q[0];
            a_q = {out_bit, a_q[7:1]};
            flg_q = {3'b000, out_bit};
         end
         OP_RLA: begin
            out_bit = a_q[7];
            a_q = {a_q[6:0], flg_q.c};
            flg_q = {3'b000, out_bit};
         end
         OP_RRA: begin
            out_bit = a_q[0];
            a_q = {flg_q.c, a_q[7:1]};
            flg_q = {3'b000, out_bit};
         end
         OP_ST_A16_SP: begin
            r.write_count = WR_TWO;
            r.write_addr = imm16;
            r.write_first = sp_q[7:0];
            r.write_second = sp_q[15:8];
            len = LEN_THREE;
         end
         OP_ADD_HL_BC: add_hl(bc_q);
         OP_ADD_HL_DE: add_hl(de_q);
         OP_LD_A_BC, OP_LD_A_DE: a_q = rq.load_data;
         OP_JR: begin
            len = LEN_TWO;
            taken = 1'b1;
         end
         OP_JR_NZ: begin
            len = LEN_TWO;
            taken = !flg_q.z;
         end
         default: ;
      endcase
      pc_q = pc_q + {14'd0, len};
      if (taken)
         pc_q = pc_q + {{8{rq.imm_low[7]}}, rq.imm_low};
      r.acc_out = a_q;
      r.flags_out = {flg_q, 4'h0};
      r.pair_bc = bc_q;
      r.pair_de = de_q;
      r.pair_hl = hl_q;
      r.next_pc = pc_q;
      r.branch_taken = taken;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap(input int pct);
      if ($urandom_range(0, 99) >= pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 3) != 0)
         return 8'($urandom);
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h0F;
         3: return 8'h10;
         4: return 8'h7F;
         5: return 8'h80;
         6: return 8'hFE;
         default: return 8'hFF;
      endcase
   endfunction

   task automatic add_item(input logic [7:0] cmd, input logic [7:0] lo,
                           input logic [7:0] hi, input logic [7:0] ld);
      req_data_type rq;
      rq.cmd = cmd;
      rq.imm_low = lo;
      rq.imm_high = hi;
      rq.load_data = ld;
      insn_q.push_back(rq);
   endtask

   task automatic add_random(input int count);
      logic [7:0] cmd;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 88)
            cmd = 8'($urandom_range(0, OP_JR_NZ));
         else
            cmd = 8'($urandom_range(OP_JR_NZ + 1, 255));
         add_item(cmd, pick_byte(), pick_byte(), 8'($urandom));
      end
   endtask

   task automatic wait_drain();
      do
         @(posedge clock);
      while (insn_q.size() != 0 || req_tvalid || result_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_sp(input logic [15:0] v);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      sp_q = v;
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            result_q.push_back(exec_insn(req_data_type'(req_tdata)));
            insn_cnt++;
         end
         if (!req_tvalid || req_tready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_tvalid <= 1'b0;
            end else if (insn_q.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= insn_q.pop_front();
               tx_gap = pick_gap(tx_idle_pct);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(input string fname, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (want_v !== got_v) begin
         err_cnt++;
         if (err_cnt <= 10)
            $display("ERROR: result %0d %s expected %h got %h",
                     result_cnt, fname, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_data_type got;
      rsp_data_type want;
      int           n;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            result_cnt++;
            if (got.branch_taken === 1'b1)
               jump_cnt++;
            if (got.write_count != WR_NONE)
               store_cnt++;
            if (result_q.size() == 0) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("ERROR: unexpected result transaction %h", got);
            end else begin
               want = result_q.pop_front();
               check_field("write_count", 16'(want.write_count), 16'(got.write_count));
               check_field("write_addr", want.write_addr, got.write_addr);
               check_field("write_first", 16'(want.write_first), 16'(got.write_first));
               check_field("write_second", 16'(want.write_second),
                           16'(got.write_second));
               check_field("acc_out", 16'(want.acc_out), 16'(got.acc_out));
               check_field("flags_out", 16'(want.flags_out), 16'(got.flags_out));
               check_field("pair_bc", want.pair_bc, got.pair_bc);
               check_field("pair_de", want.pair_de, got.pair_de);
               check_field("pair_hl", want.pair_hl, got.pair_hl);
               check_field("next_pc", want.next_pc, got.next_pc);
               check_field("branch_taken", 16'(want.branch_taken),
                           16'(got.branch_taken));
               check_field("pad", 16'(want.pad), 16'(got.pad));
            end
         end
         if (rx_hold) begin
            rsp_tready <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_tready <= 1'b0;
         end else begin
            n = pick_gap(rx_idle_pct);
            rsp_tready <= (n == 0);
            rx_stall = (n > 0) ? n - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                  cycle_cnt, result_q.size());
         $display("cpu8_opcode_subset_execute_top: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin
      a_q = '0;
      flg_q = '0;
      bc_q = '0;
      de_q = '0;
      hl_q = '0;
      pc_q = PC_RESET;
      sp_q = SP_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed sweep, SP still at its reset value
      add_item(OP_LD_BC_D16, 8'hFF, 8'hFF, 8'h00);
      add_item(OP_INC_C, 8'h00, 8'h00, 8'h00);     // FF -> 00, Z and H
      add_item(OP_JR_NZ, 8'h80, 8'h00, 8'h00);     // Z set: not taken, offset consumed
      add_item(OP_INC_B, 8'h00, 8'h00, 8'h00);
      add_item(OP_DEC_C, 8'h00, 8'h00, 8'h00);     // 00 -> FF, borrow from bit 4
      add_item(OP_DEC_B, 8'h00, 8'h00, 8'h00);
      add_item(OP_JR, 8'h80, 8'h00, 8'h00);        // backward jumps until PC wraps below 0
      add_item(OP_JR, 8'h80, 8'h00, 8'h00);
      add_item(OP_JR, 8'h80, 8'h00, 8'h00);
      add_item(OP_JR_NZ, 8'h7F, 8'h00, 8'h00);     // taken, wraps back above 0
      add_item(OP_LD_DE_D16, 8'h01, 8'h0F, 8'h00);
      add_item(OP_DEC_E, 8'h00, 8'h00, 8'h00);     // 01 -> 00, Z with N
      add_item(OP_INC_D, 8'h00, 8'h00, 8'h00);     // 0F -> 10, half carry
      add_item(OP_INC_E, 8'h00, 8'h00, 8'h00);
      add_item(OP_DEC_D, 8'h00, 8'h00, 8'h00);
      add_item(OP_INC_DE, 8'h00, 8'h00, 8'h00);
      add_item(OP_DEC_DE, 8'h00, 8'h00, 8'h00);
      add_item(OP_INC_BC, 8'h00, 8'h00, 8'h00);
      add_item(OP_DEC_BC, 8'h00, 8'h00, 8'h00);
      add_item(OP_ADD_HL_BC, 8'h00, 8'h00, 8'h00);
      add_item(OP_ADD_HL_DE, 8'h00, 8'h00, 8'h00); // carries out of bits 11 and 15
      add_item(OP_LD_A_BC, 8'h00, 8'h00, 8'h81);
      add_item(OP_RLCA, 8'h00, 8'h00, 8'h00);
      add_item(OP_RRCA, 8'h00, 8'h00, 8'h00);
      add_item(OP_RLA, 8'h00, 8'h00, 8'h00);
      add_item(OP_RRA, 8'h00, 8'h00, 8'h00);
      add_item(OP_LD_B_D8, 8'h7F, 8'hAA, 8'h00);
      add_item(OP_LD_C_D8, 8'h80, 8'h55, 8'h00);
      add_item(OP_LD_D_D8, 8'h00, 8'hFF, 8'h00);
      add_item(OP_LD_E_D8, 8'hFF, 8'h00, 8'h00);
      add_item(OP_ST_BC_A, 8'h00, 8'h00, 8'h00);
      add_item(OP_ST_DE_A, 8'h00, 8'h00, 8'h00);
      add_item(OP_LD_A_DE, 8'h00, 8'h00, 8'hFF);
      add_item(OP_ST_A16_SP, 8'hFF, 8'hFF, 8'h00);
      add_item(OP_STOP, 8'hFF, 8'hFF, 8'hFF);
      add_item(OP_NOP, 8'h00, 8'h00, 8'h00);
      add_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF);
      wait_drain();

      // random streams, one SP setting each
      write_sp(16'h0000);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      add_random(CHUNK_ITEMS);
      wait_drain();

      // sink stalls long enough for the block to back up onto the source
      write_sp(16'hFFFF);
      tx_idle_pct = 10;
      rx_idle_pct = 0;
      add_random(CHUNK_ITEMS);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
      wait_drain();

      write_sp(16'($urandom));
      tx_idle_pct = 25;
      rx_idle_pct = 25;
      add_random(CHUNK_ITEMS);
      wait_drain();

      write_sp(16'h8000);
      tx_idle_pct = 60;
      rx_idle_pct = 60;
      add_random(CHUNK_ITEMS);
      wait_drain();

      write_sp(16'h00FF);
      tx_idle_pct = 15;
      rx_idle_pct = 35;
      add_random(CHUNK_ITEMS);
      wait_drain();

      $display("Executed %0d instructions under six SP values (%0d jumps taken, %0d stores)",
               insn_cnt, jump_cnt, store_cnt);
      $display("Checked %0d results with random gaps and a %0d-cycle sink hold, %0d errors",
               result_cnt, HOLD_CYCLES, err_cnt);
      if (err_cnt == 0) begin
         $display("cpu8_opcode_subset_execute_top: match");
      end else begin
         $display("cpu8_opcode_subset_execute_top: mismatch");
      end
      $finish;
   end

endmodule
